>>> rtl/mmi_pkg.sv
`timescale 1ns / 1ps
// mmi_pkg: control word format and microcode table for the modular inverse sequencer
// depends on nothing; imported by montgomery_modular_inverse and its testbench
package mmi_pkg;

  // phase one stops after at most this many iterations
  localparam int unsigned ITER_CAP = 63;
  localparam int unsigned PC_BITS  = 4;

  // step addresses of the program
  localparam logic [PC_BITS-1:0] STEP_ITER    = 4'd0;
  localparam logic [PC_BITS-1:0] STEP_INIT_R  = 4'd1;
  localparam logic [PC_BITS-1:0] STEP_FULL_TST = 4'd2;
  localparam logic [PC_BITS-1:0] STEP_FULL_M1 = 4'd3;
  localparam logic [PC_BITS-1:0] STEP_FULL_M2 = 4'd4;
  localparam logic [PC_BITS-1:0] STEP_FULL_FIN = 4'd5;
  localparam logic [PC_BITS-1:0] STEP_PART_TST = 4'd6;
  localparam logic [PC_BITS-1:0] STEP_PART_M1 = 4'd7;
  localparam logic [PC_BITS-1:0] STEP_PART_M2 = 4'd8;
  localparam logic [PC_BITS-1:0] STEP_PART_FIN = 4'd9;
  localparam logic [PC_BITS-1:0] STEP_CHECK   = 4'd10;
  localparam logic [PC_BITS-1:0] STEP_DONE    = 4'd11;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ITER,
    OP_INIT_R,
    OP_MUL_R_MU,
    OP_MUL_CS_MU,
    OP_MUL_Q_M,
    OP_FULL_FIN,
    OP_PART_FIN,
    OP_CHECK,
    OP_DONE
  } op_t;

  // jump condition; when false the program falls through to the next step
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_LOOP,
    COND_ERR,
    COND_K_LT_W,
    COND_SKIP_PART
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } ctrl_word_t;

  // microcode rom
  function automatic ctrl_word_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_word_t w;
    case (pc)
      STEP_ITER:     w = '{OP_ITER,      COND_LOOP,      STEP_ITER};
      STEP_INIT_R:   w = '{OP_INIT_R,    COND_ERR,       STEP_CHECK};
      STEP_FULL_TST: w = '{OP_NONE,      COND_K_LT_W,    STEP_PART_TST};
      STEP_FULL_M1:  w = '{OP_MUL_R_MU,  COND_NEVER,     STEP_ITER};
      STEP_FULL_M2:  w = '{OP_MUL_Q_M,   COND_NEVER,     STEP_ITER};
      STEP_FULL_FIN: w = '{OP_FULL_FIN,  COND_NEVER,     STEP_ITER};
      STEP_PART_TST: w = '{OP_NONE,      COND_SKIP_PART, STEP_CHECK};
      STEP_PART_M1:  w = '{OP_MUL_CS_MU, COND_NEVER,     STEP_ITER};
      STEP_PART_M2:  w = '{OP_MUL_Q_M,   COND_NEVER,     STEP_ITER};
      STEP_PART_FIN: w = '{OP_PART_FIN,  COND_NEVER,     STEP_ITER};
      STEP_CHECK:    w = '{OP_CHECK,     COND_NEVER,     STEP_ITER};
      default:       w = '{OP_DONE,      COND_NEVER,     STEP_ITER};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/montgomery_modular_inverse.sv
`timescale 1ns / 1ps
// Modular inverse by the Kaliski method: each request (value, odd prime modulus m below
// 2^31, mu = -m^-1 mod 2^WORD_BITS) returns value^-1 mod m and a range error flag. Work is
// done by a small microcoded sequencer over one add/shift datapath and one 32x32 multiplier.
// One request is in flight at a time. The almost-inverse loop runs k iterations (k up to 63),
// one per cycle through the 33-bit add/subtract; for valid operands k is at most 62. The
// reduction tail runs through the multiplier steps, each registered. A finished result
// waits in an output register, and the next request can be taken while it waits, from the
// cycle after the result is registered.
// depends on mmi_pkg
module montgomery_modular_inverse
  import mmi_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // value[30:0], modulus[61:31], neg_inv_mod_word[93:62]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // inverse[30:0], zero pad
  output logic [0:0]  m_axis_tuser    // range_error[0]
);

  localparam logic [31:0] MASK  = 32'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [5:0]  WBITS = 6'(WORD_BITS);
  localparam logic [5:0]  KCAP  = 6'(ITER_CAP);

  // control
  logic               busy;
  logic [PC_BITS-1:0] pc;
  ctrl_word_t         cw;

  // datapath registers
  logic [32:0] u, v;
  logic [31:0] s, t, r, mu;
  logic [30:0] m;
  logic [5:0]  k;
  logic [63:0] prod;
  logic        err;

  // output register
  logic [30:0] inverse;
  logic        range_error;

  logic in_xfer;
  logic out_free;

  // iteration datapath
  logic        u_odd, u_flip;
  logic [32:0] u_sum, u_sel, u_next, v_next;
  logic [31:0] s_next, t_next, nt;
  logic [5:0]  k_next;
  logic        it_done, it_exit;

  // reduction datapath
  logic [5:0]  sh;
  logic [31:0] cs, r_shr, addend;
  logic [31:0] mul_a, mul_b;
  logic [32:0] lo_sum;
  logic [33:0] fin;
  logic [31:0] r_init0, r_init;
  logic        jump;

  assign cw       = ucode(pc);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = !busy;
  assign m_axis_tdata  = {1'b0, inverse};
  assign m_axis_tuser  = range_error;

  // one almost-inverse iteration
  always_comb begin
    u_odd   = u[0];
    u_sum   = (u[32] != v[32]) ? u + v : u - v;
    u_flip  = u_odd && (u_sum[32] != u[32]);
    u_sel   = u_odd ? u_sum : u;
    u_next  = {u_sel[32], u_sel[32:1]};
    v_next  = u_flip ? u : v;
    nt      = u_flip ? s : t;
    s_next  = u_odd ? s + t : s;
    t_next  = {nt[30:0], 1'b0};
    k_next  = k + 6'd1;
    it_done = (u_next == 33'd0);
    it_exit = it_done || (k_next == KCAP);
  end

  // starting remainder, shifted forms and multiplier operands
  always_comb begin
    r_init0 = {1'b0, m} - t;
    r_init  = r_init0[31] ? r_init0 + {1'b0, m} : r_init0;
    sh      = WBITS - k;
    cs      = (r << sh[4:0]) & MASK;
    r_shr   = r >> k[4:0];
    case (cw.op)
      OP_MUL_CS_MU: mul_a = cs;
      OP_MUL_Q_M:   mul_a = prod[31:0] & MASK;
      default:      mul_a = r;
    endcase
    mul_b  = (cw.op == OP_MUL_Q_M) ? {1'b0, m} : (mu & MASK);
    addend = (cw.op == OP_PART_FIN) ? cs : r;
    lo_sum = {1'b0, prod[31:0] & MASK} + {1'b0, addend};
    fin    = 34'(prod >> WORD_BITS) + 34'(lo_sum >> WORD_BITS)
           + ((cw.op == OP_PART_FIN) ? {2'b0, r_shr} : 34'd0);
  end

  // jump decision
  always_comb begin
    case (cw.cond)
      COND_LOOP:      jump = !it_exit;
      COND_ERR:       jump = err;
      COND_K_LT_W:    jump = (k < WBITS);
      COND_SKIP_PART: jump = err || (k == 6'd0);
      default:        jump = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_ITER;
    end else if (!busy) begin
      if (in_xfer) begin
        busy <= 1'b1;
        pc   <= STEP_ITER;
      end
    end else if (cw.op == OP_DONE) begin
      if (out_free) begin
        busy <= 1'b0;
        pc   <= STEP_ITER;
      end
    end else begin
      pc <= jump ? cw.target : pc + 4'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (!busy) begin
      if (in_xfer) begin
        u    <= {2'b0, s_axis_tdata[30:0]};
        v    <= {2'b0, s_axis_tdata[61:31]};
        m    <= s_axis_tdata[61:31];
        mu   <= s_axis_tdata[93:62];
        s    <= 32'd1;
        t    <= 32'd0;
        k    <= 6'd0;
        err  <= 1'b0;
      end
    end else begin
      case (cw.op)
        OP_ITER: begin
          u <= u_next;
          v <= v_next;
          s <= s_next;
          t <= t_next;
          k <= k_next;
          if (it_exit && !it_done) err <= 1'b1;
        end
        OP_INIT_R: r <= r_init;
        OP_MUL_R_MU, OP_MUL_CS_MU, OP_MUL_Q_M: prod <= 64'(mul_a) * 64'(mul_b);
        OP_FULL_FIN: begin
          r <= fin[31:0];
          k <= k - WBITS;
          if ((k - WBITS) >= WBITS) err <= 1'b1;
        end
        OP_PART_FIN: r <= fin[31:0];
        OP_CHECK: if (r >= {1'b0, m}) err <= 1'b1;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (busy && cw.op == OP_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
        inverse       <= err ? 31'd0 : r[30:0];
        range_error   <= err;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // an error result carries a zero inverse
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("error result with nonzero inverse");

  // a new result appears only from the final program step
  a_rose_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(busy && cw.op == OP_DONE))
    else $error("result raised outside the done step");

  // iteration count never passes the cap
  a_k_cap: assert property (@(posedge clk) disable iff (rst)
    busy |-> k <= KCAP)
    else $error("iteration count beyond cap");

  // program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= STEP_DONE)
    else $error("program counter out of range");

endmodule

>>> sim/montgomery_modular_inverse_tb.sv
`timescale 1ns / 1ps
// montgomery_modular_inverse_tb: self-checking stream testbench for the modular inverse block
// depends on mmi_pkg and montgomery_modular_inverse; results are checked against typed table values
// or an in-bench model of the Kaliski almost-inverse loop and the Montgomery correction
module montgomery_modular_inverse_tb
  import mmi_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS    = 650;
  localparam int unsigned STALL_AT_RESULT = 150;
  localparam int unsigned STALL_CYCLES    = 400;
  localparam int unsigned PAUSE_AT_ITEM   = 420;
  localparam int unsigned TAIL_CYCLES     = 100;
  localparam bit [30:0]   MAX_MODULUS     = 31'h7FFFFFFF;
  localparam bit [30:0]   NEAR_MODULUS    = 31'd2147483629;

  typedef struct {
    bit [30:0] value;
    bit [30:0] modulus;
    bit [31:0] mu;
    bit        typed;
    bit [30:0] inverse;
    bit        range_error;
    bit        well_formed;
  } request_t;

  typedef struct {
    bit [30:0] inverse;
    bit        range_error;
  } inverse_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // value[30:0], modulus[61:31], neg_inv_mod_word[93:62]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // inverse[30:0], zero pad
  logic [0:0]  m_axis_tuser;        // range_error[0]

  inverse_t    pending_inverses[$];
  request_t    directed[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned error_results = 0;
  int unsigned requests_sent = 0;
  int unsigned well_formed_sent = 0;

  montgomery_modular_inverse u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // append one row to the directed table
  function automatic void add_row(request_t row);
    directed.insert(directed.size(), row);
  endfunction

  // almost-inverse loop, then full and partial montgomery steps to strip 2^k
  function automatic inverse_t kaliski_inverse(bit [30:0] x, bit [30:0] m, bit [31:0] mu);
    inverse_t    res;
    longint      u, v, old;
    bit [31:0]   s, t, nt, r, cs, q32;
    bit [63:0]   prod, sum;
    int unsigned k;
    bit          finished;
    u = longint'(x);
    v = longint'(m);
    s = 32'd1;
    t = 32'd0;
    k = 0;
    finished = 1'b0;
    while (k < ITER_CAP && !finished) begin
      nt = t;
      if (u[0]) begin
        old = u;
        if ((old < 0) != (v < 0)) u = u + v;
        else u = u - v;
        // sign flip swaps roles: old u becomes v, next t comes from s
        if ((u < 0) != (old < 0)) begin
          v = old;
          nt = s;
        end
        s = s + t;
      end
      u = u >>> 1;
      k++;
      t = nt << 1;
      if (u == 0) finished = 1'b1;
    end

    r = {1'b0, m} - t;
    if (r[31]) r = r + {1'b0, m};

    // full reduction divides by 2^32
    if (finished && k >= 32) begin
      q32 = r * mu;
      prod = 64'(q32) * 64'(m);
      sum = 64'(prod[31:0]) + 64'(r);
      r = prod[63:32] + sum[63:32];
      k -= 32;
    end
    // partial reduction removes the remaining 2^k
    if (finished && k != 0) begin
      cs = r << (32 - k);
      q32 = cs * mu;
      prod = 64'(q32) * 64'(m);
      sum = 64'(prod[31:0]) + 64'(cs);
      r = prod[63:32] + (r >> k) + sum[63:32];
    end

    res.range_error = !finished || (r >= {1'b0, m});
    res.inverse = res.range_error ? 31'd0 : r[30:0];
    return res;
  endfunction

  // -m^-1 mod 2^32 by newton iteration, meaningful for odd m only
  function automatic bit [31:0] neg_inv_word(bit [30:0] m);
    bit [31:0] inv;
    inv = {1'b0, m};
    repeat (5) inv = inv * (32'd2 - {1'b0, m} * inv);
    return -inv;
  endfunction

  // odd prime, mostly of random size, often full width
  function automatic bit [30:0] random_prime();
    int unsigned     width;
    bit [31:0]       cand;
    longint unsigned d;
    bit              composite;
    width = ($urandom_range(9, 0) < 3) ? 31 : $urandom_range(31, 2);
    cand = $urandom_range((32'd1 << width) - 1, 32'd1 << (width - 1)) | 32'd1;
    composite = 1'b1;
    while (composite) begin
      composite = 1'b0;
      for (d = 3; d * d <= cand && !composite; d += 2)
        if (cand % d == 0) composite = 1'b1;
      if (composite) cand = (cand >= 32'h7FFFFFFD) ? 32'd3 : cand + 32'd2;
    end
    return cand[30:0];
  endfunction

  // mostly well-formed requests, the rest bad operands of several sorts
  function automatic request_t draw_request();
    request_t    rq;
    int unsigned pick;
    rq.typed = 1'b0;
    rq.inverse = '0;
    rq.range_error = 1'b0;
    rq.modulus = random_prime();
    rq.value = 31'($urandom_range(32'(rq.modulus) - 1, 1));
    rq.mu = neg_inv_word(rq.modulus);
    pick = $urandom_range(99, 0);
    rq.well_formed = (pick < 80);
    if (pick >= 97) begin
      // fully random fields
      rq.value = 31'($urandom);
      rq.modulus = 31'($urandom);
      rq.mu = $urandom;
    end else if (pick >= 94) begin
      // zero value or value equal to the modulus
      rq.value = pick[0] ? 31'd0 : rq.modulus;
    end else if (pick >= 90) begin
      // wrong montgomery constant
      rq.mu = $urandom;
    end else if (pick >= 86) begin
      // arbitrary modulus, possibly even or composite
      rq.modulus = 31'($urandom);
      rq.value = 31'($urandom);
      rq.mu = neg_inv_word(rq.modulus);
    end else if (pick >= 80) begin
      // value at or above the modulus
      rq.value = 31'($urandom_range(32'h7FFFFFFF, 32'(rq.modulus)));
    end
    return rq;
  endfunction

  // offer one request after a random gap (none when calm) and queue its expected inverse on transfer
  task automatic send_request(input request_t rq, input bit calm);
    inverse_t    want;
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(4, 0);
    if (rq.typed) begin
      want.inverse = rq.inverse;
      want.range_error = rq.range_error;
    end else begin
      want = kaliski_inverse(rq.value, rq.modulus, rq.mu);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, rq.mu, rq.modulus, rq.value};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_inverses.insert(pending_inverses.size(), want);
    requests_sent++;
    if (rq.well_formed) well_formed_sent++;
  endtask

  // output side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (((results_seen / 50) % 5) == 2) ? 0 : $urandom_range(4, 0);
      if (!held && results_seen >= STALL_AT_RESULT) begin
        gap = STALL_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // compare each output transfer with the oldest pending inverse
  always @(posedge clk) begin : check_output
    inverse_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0]) error_results++;
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: inverse %0d range_error %0b",
                   m_axis_tdata[30:0], m_axis_tuser[0]);
      end else begin
        want = pending_inverses.pop_front();
        if (m_axis_tdata[30:0] !== want.inverse || m_axis_tuser[0] !== want.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: inverse %0d range_error %0b, expected inverse %0d range_error %0b",
                     results_seen, m_axis_tdata[30:0], m_axis_tuser[0],
                     want.inverse, want.range_error);
        end
      end
    end
  end

  // stimulus: directed table, then random requests
  initial begin
    request_t    rq;
    int unsigned i;
    // typed rows (one predicted): inverse of 1 and of m-1, zero value, value equal to m, zero modulus
    add_row('{31'd1, 31'd3, neg_inv_word(31'd3), 1'b1, 31'd1, 1'b0, 1'b1});
    add_row('{31'd2, 31'd3, neg_inv_word(31'd3), 1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{31'd1, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b1, 31'd1, 1'b0, 1'b1});
    add_row('{MAX_MODULUS - 31'd1, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b1, MAX_MODULUS - 31'd1, 1'b0, 1'b1});
    add_row('{31'd65536, 31'd65537, neg_inv_word(31'd65537),
              1'b1, 31'd65536, 1'b0, 1'b1});
    add_row('{31'd0, 31'd7, neg_inv_word(31'd7), 1'b1, 31'd0, 1'b1, 1'b0});
    add_row('{31'd0, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b1, 31'd0, 1'b1, 1'b0});
    add_row('{31'd13, 31'd13, neg_inv_word(31'd13), 1'b1, 31'd0, 1'b1, 1'b0});
    add_row('{MAX_MODULUS, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b1, 31'd0, 1'b1, 1'b0});
    add_row('{31'd5, 31'd0, 32'd0, 1'b1, 31'd0, 1'b1, 1'b0});
    // predicted rows: small and large moduli, bad operands, extreme mu
    add_row('{31'd2, 31'd5, neg_inv_word(31'd5), 1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{31'd12345, 31'd65537, neg_inv_word(31'd65537),
              1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{31'h40000000, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{31'h55555555, MAX_MODULUS, neg_inv_word(MAX_MODULUS),
              1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{31'h2AAAAAAA, NEAR_MODULUS, neg_inv_word(NEAR_MODULUS),
              1'b0, 31'd0, 1'b0, 1'b1});
    add_row('{MAX_MODULUS, NEAR_MODULUS, neg_inv_word(NEAR_MODULUS),
              1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{MAX_MODULUS, 31'd3, neg_inv_word(31'd3), 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd0, 31'd1, neg_inv_word(31'd1), 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd1, 31'd1, neg_inv_word(31'd1), 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd3, 31'd10, 32'd0, 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd6, 31'd9, neg_inv_word(31'd9), 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd5, 31'd101, 32'd0, 1'b0, 31'd0, 1'b0, 1'b0});
    add_row('{31'd12345, MAX_MODULUS, 32'hFFFFFFFF, 1'b0, 31'd0, 1'b0, 1'b0});

    // reset
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed.size(); i++) send_request(directed[i], 1'b0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // drain everything once, then resume
      if (i == PAUSE_AT_ITEM) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_inverses.size() != 0) @(posedge clk);
      end
      rq = draw_request();
      send_request(rq, ((i / 50) % 5) == 4);
    end

    // wait for the tail, then report
    s_axis_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d requests (%0d directed, %0d well-formed), checked %0d results",
             requests_sent, directed.size(), well_formed_sent, results_seen);
    $display("%0d results flagged range_error, %0d mismatches", error_results, mismatches);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("watchdog expired with %0d results pending", pending_inverses.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
